// ===== src/ctach_pkg.sv =====
// shared constants and codes for the capture tachometer
package ctach_pkg;

   // default build values
   localparam int CAPTURE_CLOCK_HZ_DEF = 80000000;
   localparam int FRACTION_BITS_DEF    = 8;

   // fixed field widths
   localparam int STAMP_W   = 32;
   localparam int FREQ_W    = 35;
   localparam int RPM_W     = 41;
   localparam int POLE_W    = 4;
   localparam int TIMEOUT_W = 16;
   localparam int ELAPSED_W = 16;
   localparam int RPM_MUL_W = 6;
   localparam logic [RPM_MUL_W-1:0] RPM_FACTOR = 6'd60;

   // register reset values
   localparam logic [POLE_W-1:0]    PAIR_COUNT_RST = 4'd2;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd500;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PAIR_COUNT = 1'b0;
   localparam logic REG_TIMEOUT_MS = 1'b1;

   // item operation codes
   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

endpackage

// ===== src/ctach_if.sv =====
// valid/ready channel interfaces for request and response items
interface ctach_req_if
   import ctach_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [STAMP_W-1:0] capture_value;

   modport source (output valid, output operation, output capture_value, input ready);
   modport sink (input valid, input operation, input capture_value, output ready);
endinterface

interface ctach_rsp_if
   import ctach_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FREQ_W-1:0]  frequency_q8;
   logic [RPM_W-1:0]   rpm_q8;
   logic               signal_present;
   logic [STAMP_W-1:0] period_ticks;

   modport source (output valid, output frequency_q8, output rpm_q8,
                   output signal_present, output period_ticks, input ready);
   modport sink (input valid, input frequency_q8, input rpm_q8,
                 input signal_present, input period_ticks, output ready);
endinterface

// ===== src/capture_tachometer.sv =====
// capture tachometer top level with shared restoring divider
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    operation, capture_value
//   rsp_ch   out  valid/ready    frequency_q8, rpm_q8, signal_present, period_ticks
//   csr_*    in   apb write/read pair_count (0x0), timeout_ms (0x4)
//
// one item at a time: a tick, or a capture without a new period, runs the signal-loss
// check, the multiply and the rpm division; a capture with a new nonzero period runs the
// clock/period division first. Both divisions use the one-bit-per-cycle divider, first
// for clock/period and then for rpm over pole pairs.
// reset is synchronous; a result waiting on rsp_ch holds the sequencer in its
// last step while the next item can already be taken once it is handed over.
module capture_tachometer
   import ctach_pkg::*;
#(
   parameter int CAPTURE_CLOCK_HZ = CAPTURE_CLOCK_HZ_DEF,
   parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ctach_req_if.sink             req_ch,
   ctach_rsp_if.source           rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // divider sizing follows from the capture clock, the fraction and the rpm width
   localparam int NUM_W = $clog2(CAPTURE_CLOCK_HZ + 1) + FRACTION_BITS;
   localparam int DIV_W = (NUM_W > RPM_W) ? NUM_W : RPM_W;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam logic [63:0] NUM64 = 64'(CAPTURE_CLOCK_HZ) << FRACTION_BITS;
   localparam logic [DIV_W-1:0] NUMERATOR = DIV_W'(NUM64);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIVF, ST_CHECK, ST_MULT, ST_DIVR, ST_DONE
   } state_type;

   // configuration registers
   logic [POLE_W-1:0]    pair_count_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 csr_wr;
   logic                 csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= PAIR_COUNT_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PAIR_COUNT: pair_count_ff <= csr_pwdata[POLE_W-1:0];
            REG_TIMEOUT_MS: timeout_ff    <= csr_pwdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_PAIR_COUNT: csr_prdata = CSR_DATA_W'(pair_count_ff);
         REG_TIMEOUT_MS: csr_prdata = CSR_DATA_W'(timeout_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // measurement state and sequencer
   state_type            state_ff, state_in;
   logic [STAMP_W-1:0]   prev_ff, prev_in;
   logic                 have_ff, have_in;
   logic [STAMP_W-1:0]   period_ff, period_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // shared divider registers
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [STAMP_W-1:0]   rem_ff, rem_in;
   logic [STAMP_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // response registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;
   logic [RPM_W-1:0]     rsp_rpm_ff, rsp_rpm_in;
   logic                 rsp_present_ff, rsp_present_in;
   logic [STAMP_W-1:0]   rsp_period_ff, rsp_period_in;

   // one restoring step of the divider
   logic [STAMP_W:0]     shifted;
   logic [STAMP_W:0]     trial;
   logic                 qbit;
   logic [STAMP_W-1:0]   step_rem;
   logic [DIV_W-1:0]     step_quo;

   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign qbit     = ~trial[STAMP_W];
   assign step_rem = qbit ? trial[STAMP_W-1:0] : shifted[STAMP_W-1:0];
   assign step_quo = {quo_ff[DIV_W-2:0], qbit};

   logic                 accept;
   logic [STAMP_W-1:0]   diff;
   logic [RPM_W-1:0]     scaled;
   logic                 rsp_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;
   assign diff         = req_ch.capture_value - prev_ff;
   assign scaled       = RPM_W'(freq_ff) * RPM_W'(RPM_FACTOR);
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      prev_in        = prev_ff;
      have_in        = have_ff;
      period_in      = period_ff;
      freq_in        = freq_ff;
      elapsed_in     = elapsed_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      cnt_in         = cnt_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_rpm_in     = rsp_rpm_ff;
      rsp_present_in = rsp_present_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;

      case (state_ff)
         // take the item and update capture or tick state
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
               if (req_ch.operation == OP_TICK) begin
                  if (elapsed_ff != ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end else begin
                  prev_in = req_ch.capture_value;
                  have_in = 1'b1;
                  if (have_ff) begin
                     period_in = diff;
                     if (diff != '0) begin
                        elapsed_in = '0;
                        quo_in     = NUMERATOR;
                        rem_in     = '0;
                        dvs_in     = diff;
                        cnt_in     = CNT_W'(DIV_W);
                        state_in   = ST_DIVF;
                     end
                  end
               end
            end
         end
         // clock over period, one quotient bit a cycle
         ST_DIVF: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               freq_in  = step_quo[FREQ_W-1:0];
               state_in = ST_CHECK;
            end
         end
         // signal loss
         ST_CHECK: begin
            if (elapsed_ff > timeout_ff) begin
               freq_in = '0;
            end
            state_in = ST_MULT;
         end
         // frequency times sixty into the divider
         ST_MULT: begin
            quo_in   = DIV_W'(scaled);
            rem_in   = '0;
            dvs_in   = (pair_count_ff == '0) ? STAMP_W'(1) : STAMP_W'(pair_count_ff);
            cnt_in   = CNT_W'(DIV_W);
            state_in = ST_DIVR;
         end
         // rpm over pole pairs
         ST_DIVR: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         // hand the item to the response register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_freq_in    = freq_ff;
               rsp_rpm_in     = quo_ff[RPM_W-1:0];
               rsp_present_in = (freq_ff != '0) && (elapsed_ff < timeout_ff);
               rsp_period_in  = period_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         period_ff    <= '0;
         freq_ff      <= '0;
         elapsed_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         period_ff    <= period_in;
         freq_ff      <= freq_in;
         elapsed_ff   <= elapsed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers without reset
   always_ff @(posedge clock) begin
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      rsp_freq_ff    <= rsp_freq_in;
      rsp_rpm_ff     <= rsp_rpm_in;
      rsp_present_ff <= rsp_present_in;
      rsp_period_ff  <= rsp_period_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.frequency_q8   = rsp_freq_ff;
   assign rsp_ch.rpm_q8         = rsp_rpm_ff;
   assign rsp_ch.signal_present = rsp_present_ff;
   assign rsp_ch.period_ticks   = rsp_period_ff;

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the capture tachometer: directed, register and random traffic
`timescale 1ns / 100ps

module tb_top;
   import ctach_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_OFF     = 400;
   localparam int PHASE_ITEMS  = 440;
   localparam int REPORT_MAX   = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PAIR_COUNT = {REG_PAIR_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_TIMEOUT_MS = {REG_TIMEOUT_MS, 2'b00};
   localparam logic [63:0] FREQ_NUMERATOR = 64'(CAPTURE_CLOCK_HZ_DEF) << FRACTION_BITS_DEF;
   localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

   typedef struct packed {
      logic [FREQ_W-1:0]  frequency_q8;
      logic [RPM_W-1:0]   rpm_q8;
      logic               signal_present;
      logic [STAMP_W-1:0] period_ticks;
   } reading_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ctach_req_if req_if ();
   ctach_rsp_if rsp_if ();

   capture_tachometer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // tachometer state mirrored by the bench
   logic [STAMP_W-1:0]   prev_stamp  = '0;
   logic                 have_prev   = 1'b0;
   logic [STAMP_W-1:0]   period_q    = '0;
   logic [FREQ_W-1:0]    freq_q      = '0;
   logic [ELAPSED_W-1:0] elapsed_q   = '0;
   logic [POLE_W-1:0]    pole_cfg    = PAIR_COUNT_RST;
   logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RST;

   reading_type        expected_readings[$];
   int                 mismatches = 0;
   int                 send_idle_pct;
   int                 rsp_idle_pct;
   int                 hold_rsp_cycles;
   int                 quiet_cycles;
   logic [STAMP_W-1:0] last_stamp = '0;

   // clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // advance the mirrored state by one item and return the reading it produces
   function automatic reading_type predict_reading(input logic op,
                                                   input logic [STAMP_W-1:0] stamp);
      reading_type        r;
      logic [STAMP_W-1:0] diff;
      logic [63:0]        quot;
      logic [63:0]        divisor;
      if (op == OP_CAPTURE) begin
         if (have_prev) begin
            diff     = stamp - prev_stamp;
            period_q = diff;
            if (diff != '0) begin
               quot      = FREQ_NUMERATOR / {32'd0, diff};
               freq_q    = quot[FREQ_W-1:0];
               elapsed_q = '0;
            end
         end
         prev_stamp = stamp;
         have_prev  = 1'b1;
      end else if (elapsed_q != ELAPSED_SAT) begin
         elapsed_q = elapsed_q + 1'b1;
      end
      // signal lost
      if (elapsed_q > timeout_cfg)
         freq_q = '0;
      divisor = (pole_cfg == '0) ? 64'd1 : 64'(pole_cfg);
      quot    = (64'(freq_q) * 64'(RPM_FACTOR)) / divisor;
      r.frequency_q8   = freq_q;
      r.rpm_q8         = quot[RPM_W-1:0];
      r.signal_present = (freq_q != '0) && (elapsed_q < timeout_cfg);
      r.period_ticks   = period_q;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch: result item with no item pending");
         end else begin
            want = expected_readings.pop_front();
            check_field("frequency_q8", 64'(want.frequency_q8), 64'(rsp_if.frequency_q8));
            check_field("rpm_q8", 64'(want.rpm_q8), 64'(rsp_if.rpm_q8));
            check_field("signal_present", 64'(want.signal_present),
                        64'(rsp_if.signal_present));
            check_field("period_ticks", 64'(want.period_ticks), 64'(rsp_if.period_ticks));
         end
      end
   end

   // result receiver with random stalls and an optional long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_rsp_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // offer one item and record its expected reading once accepted
   task automatic send_item(input logic op, input logic [STAMP_W-1:0] stamp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.operation     <= op;
      req_if.capture_value <= stamp;
      do @(posedge clock); while (!req_if.ready);
      expected_readings.push_back(predict_reading(op, stamp));
      if (op == OP_CAPTURE)
         last_stamp = stamp;
   endtask

   // mostly well-formed capture trains with ticks between, some noise
   task automatic send_random_item();
      int                 pick;
      logic [STAMP_W-1:0] gap;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_item(OP_CAPTURE, $urandom);
      end else if (pick < 13) begin
         send_item(OP_CAPTURE, last_stamp);
      end else if (pick < 50) begin
         case ($urandom_range(3))
            0:       gap = $urandom_range(255, 1);
            1:       gap = $urandom_range(65535, 256);
            2:       gap = $urandom_range(2000000, 1000);
            default: gap = $urandom;
         endcase
         send_item(OP_CAPTURE, last_stamp + gap);
      end else begin
         send_item(OP_TICK, $urandom);
      end
   endtask

   // stop offering and wait for every pending reading
   task automatic wait_results_done();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0)
         @(posedge clock);
   endtask

   task automatic apb_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // register write while idle, then read back
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      wait_results_done();
      apb_access(1'b1, addr, value, readback);
      if (addr == ADDR_PAIR_COUNT)
         pole_cfg = value[POLE_W-1:0];
      else
         timeout_cfg = value[TIMEOUT_W-1:0];
      apb_access(1'b0, addr, '0, readback);
      check_field("register readback", 64'(value), 64'(readback));
   endtask

   // arming, zero period, shortest and longest periods, wraparound, at reset settings
   task automatic test_extremes();
      send_item(OP_TICK, 32'hFFFF_FFFF);
      send_item(OP_CAPTURE, 32'h0000_0000);
      send_item(OP_CAPTURE, 32'h0000_0000);
      send_item(OP_CAPTURE, 32'h0000_0001);
      send_item(OP_CAPTURE, 32'h0000_0001);
      send_item(OP_CAPTURE, 32'h0000_0000);
      send_item(OP_CAPTURE, 32'hFFFF_FFFF);
      send_item(OP_CAPTURE, 32'h0000_0000);
      send_item(OP_CAPTURE, 32'd80000);
      send_item(OP_TICK, 32'h0000_0000);
      send_item(OP_CAPTURE, 32'h5555_5555);
      send_item(OP_CAPTURE, 32'hAAAA_AAAA);
   endtask

   // timeout expiry and recovery, pole pairs zero and fifteen, timeout zero and largest
   task automatic test_registers();
      write_reg(ADDR_PAIR_COUNT, 32'd12);
      write_reg(ADDR_TIMEOUT_MS, 32'd2);
      send_item(OP_CAPTURE, last_stamp + 32'd80000);
      repeat (3) send_item(OP_TICK, $urandom);
      send_item(OP_CAPTURE, last_stamp + 32'd160000);
      write_reg(ADDR_PAIR_COUNT, 32'd0);
      send_item(OP_CAPTURE, last_stamp + 32'd777);
      write_reg(ADDR_PAIR_COUNT, 32'd15);
      send_item(OP_CAPTURE, last_stamp + 32'd3);
      write_reg(ADDR_TIMEOUT_MS, 32'd0);
      send_item(OP_CAPTURE, last_stamp + 32'd5000);
      send_item(OP_TICK, $urandom);
      write_reg(ADDR_TIMEOUT_MS, 32'd65535);
      write_reg(ADDR_PAIR_COUNT, 32'd1);
      send_item(OP_CAPTURE, last_stamp + 32'd1);
      send_item(OP_TICK, $urandom);
   endtask

   // random traffic in four chunks, new settings between chunks
   task automatic test_random_traffic(input int s_idle, input int r_idle,
                                      input logic [POLE_W-1:0] first_pole,
                                      input logic [TIMEOUT_W-1:0] first_timeout);
      send_idle_pct = s_idle;
      rsp_idle_pct  = r_idle;
      for (int chunk = 0; chunk < 4; chunk++) begin
         if (chunk == 0) begin
            write_reg(ADDR_PAIR_COUNT, CSR_DATA_W'(first_pole));
            write_reg(ADDR_TIMEOUT_MS, CSR_DATA_W'(first_timeout));
         end else begin
            write_reg(ADDR_PAIR_COUNT, $urandom_range(15));
            if ($urandom_range(5) == 0)
               write_reg(ADDR_TIMEOUT_MS, $urandom_range(65535));
            else
               write_reg(ADDR_TIMEOUT_MS, $urandom_range(12, 1));
         end
         repeat (PHASE_ITEMS / 4) send_random_item();
      end
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_long_stall();
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      hold_rsp_cycles = HOLD_OFF;
      repeat (12) send_random_item();
      wait_results_done();
   endtask

   initial begin
      reset                = 1'b1;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_CAPTURE;
      req_if.capture_value = '0;
      send_idle_pct        = 20;
      rsp_idle_pct         = 20;
      hold_rsp_cycles      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_registers();
      test_random_traffic(36, 86, 4'd1, 16'd1);
      test_long_stall();
      test_random_traffic(86, 36, 4'd12, 16'd65535);
      test_random_traffic(0, 0, 4'd15, 16'd0);

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
